### sv/hrbf_pkg.sv
package hrbf_pkg;

    localparam int LENGTH_WIDTH_DEF  = 32;
    localparam int SIZE_LINE_MAX_DEF = 30;
    localparam logic [15:0] MAX_HEAD_LEN_RST = 16'd8192;

    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_BODY  = 3'd1;
    localparam logic [2:0] PH_SIZE  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRLF  = 3'd4;
    localparam logic [2:0] PH_FINAL = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HEAD_LEN = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_SIZE     = 3'd3;
    localparam logic [2:0] ERR_SIZE_LEN = 3'd4;
    localparam logic [2:0] ERR_CRLF     = 3'd5;
    localparam logic [2:0] ERR_FINAL    = 3'd6;

    localparam logic [1:0] VS_NONE = 2'd0;
    localparam logic [1:0] VS_LEN  = 2'd1;
    localparam logic [1:0] VS_CONN = 2'd2;
    localparam logic [1:0] VS_TE   = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam logic [135:0] W_CL      = "content-length";
    localparam logic [135:0] W_CONN    = "connection";
    localparam logic [135:0] W_TE      = "transfer-encoding";
    localparam logic [135:0] W_CHUNKED = "chunked";
    localparam logic [135:0] W_KA      = "keep-alive";
    localparam logic [135:0] W_CLOSE   = "close";

    typedef struct packed {
        logic       first;
        logic       stage;
        logic [4:0] pos;
        logic       ws;
        logic       started;
        logic       bad;
        logic [2:0] nm;
        logic [1:0] vs;
    } ln_t;

    localparam ln_t LN_START = '{first: 1'b1, stage: 1'b0, pos: 5'd0, ws: 1'b0,
                                 started: 1'b0, bad: 1'b0, nm: 3'd7, vs: VS_NONE};

    typedef struct packed {
        logic line_done;
        logic eol_bad;
        logic len_we;
        logic chunk_set;
        logic ka_we;
        logic ka_val;
    } hl_ctl_t;

    typedef struct packed {
        logic       forward;
        logic [2:0] phase;
        logic       msg_end;
        logic       close_after;
        logic [2:0] error_code;
    } res_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    // True when the word has character c at position pos.
    function automatic logic word_hit(input logic [135:0] w, input int len,
                                      input logic [4:0] pos, input logic [7:0] c);
        int idx;
        idx = 8 * (len - 1 - int'(pos));
        if (int'(pos) >= len)
            return 1'b0;
        return w[idx +: 8] == c;
    endfunction

endpackage

### sv/hrbf_hdr_line.sv
module hrbf_hdr_line #(
    parameter int LENGTH_WIDTH = hrbf_pkg::LENGTH_WIDTH_DEF
) (
    input  hrbf_pkg::ln_t           ln,
    input  logic [LENGTH_WIDTH-1:0] val,
    input  logic                    pend_cr,
    input  logic [7:0]              data_byte,
    output hrbf_pkg::ln_t           ln_next,
    output logic [LENGTH_WIDTH-1:0] val_next,
    output logic                    pend_cr_next,
    output hrbf_pkg::hl_ctl_t       ctl
);

    localparam int LW = LENGTH_WIDTH;

    function automatic logic [4:0] pos_inc(input logic [4:0] p);
        return (p == 5'h1F) ? p : p + 5'd1;
    endfunction

    function automatic void tok_end(input hrbf_pkg::ln_t s, output hrbf_pkg::ln_t so,
                                    output logic we, output logic kv);
        so = s;
        we = 1'b0;
        kv = 1'b0;
        if (s.nm[0] && s.pos == 5'd10)
        begin
            we = 1'b1;
            kv = 1'b1;
        end
        else if (s.nm[1] && s.pos == 5'd5)
        begin
            we = 1'b1;
        end
        so.nm = 3'd3;
        so.pos = 5'd0;
        so.ws = 1'b0;
        so.started = 1'b0;
    endfunction

    function automatic void char_step(input hrbf_pkg::ln_t s, input logic [LW-1:0] v,
                                      input logic [7:0] c, output hrbf_pkg::ln_t so,
                                      output logic [LW-1:0] vo, output logic we,
                                      output logic kv);
        logic [7:0]    lc;
        logic [1:0]    kind;
        logic [LW+3:0] prod;
        so = s;
        vo = v;
        we = 1'b0;
        kv = 1'b0;
        lc = hrbf_pkg::to_lower(c);
        kind = hrbf_pkg::VS_NONE;
        prod = '0;
        if (!s.first)
        begin
            if (!s.stage)
            begin
                if (c == hrbf_pkg::CH_COLON)
                begin
                    if (s.nm[0] && s.pos == 5'd14) kind = hrbf_pkg::VS_LEN;
                    if (s.nm[1] && s.pos == 5'd10) kind = hrbf_pkg::VS_CONN;
                    if (s.nm[2] && s.pos == 5'd17) kind = hrbf_pkg::VS_TE;
                    so.vs = kind;
                    so.stage = 1'b1;
                    so.pos = 5'd0;
                    so.ws = 1'b0;
                    so.started = 1'b0;
                    so.bad = 1'b0;
                    vo = '0;
                    so.nm = (kind == hrbf_pkg::VS_CONN) ? 3'd3 : 3'd1;
                end
                else if (hrbf_pkg::is_blank(c))
                begin
                    so.ws = 1'b1;
                end
                else
                begin
                    so.nm[0] = s.nm[0] && !s.ws && hrbf_pkg::word_hit(hrbf_pkg::W_CL, 14, s.pos, lc);
                    so.nm[1] = s.nm[1] && !s.ws
                               && hrbf_pkg::word_hit(hrbf_pkg::W_CONN, 10, s.pos, lc);
                    so.nm[2] = s.nm[2] && !s.ws && hrbf_pkg::word_hit(hrbf_pkg::W_TE, 17, s.pos, lc);
                    so.pos = pos_inc(s.pos);
                end
            end
            else
            begin
                unique case (s.vs)
                    hrbf_pkg::VS_LEN:
                    begin
                        if (s.started || !hrbf_pkg::is_blank(c))
                        begin
                            so.started = 1'b1;
                            if (c >= 8'h30 && c <= 8'h39)
                            begin
                                prod = ({4'b0, v} << 3) + ({4'b0, v} << 1)
                                       + (LW+4)'(c - 8'h30);
                                if (prod[LW+3:LW] != 4'd0)
                                    so.bad = 1'b1;
                                else
                                    vo = prod[LW-1:0];
                            end
                            else
                            begin
                                so.bad = 1'b1;
                            end
                        end
                    end
                    hrbf_pkg::VS_TE:
                    begin
                        if (s.started || !hrbf_pkg::is_blank(c))
                        begin
                            so.started = 1'b1;
                            so.nm[0] = s.nm[0]
                                       && hrbf_pkg::word_hit(hrbf_pkg::W_CHUNKED, 7, s.pos, lc);
                            so.pos = pos_inc(s.pos);
                        end
                    end
                    hrbf_pkg::VS_CONN:
                    begin
                        if (c == hrbf_pkg::CH_SEMI)
                        begin
                            tok_end(s, so, we, kv);
                        end
                        else if (hrbf_pkg::is_blank(c))
                        begin
                            if (s.started) so.ws = 1'b1;
                        end
                        else
                        begin
                            so.started = 1'b1;
                            so.nm[0] = s.nm[0] && !s.ws
                                       && hrbf_pkg::word_hit(hrbf_pkg::W_KA, 10, s.pos, lc);
                            so.nm[1] = s.nm[1] && !s.ws
                                       && hrbf_pkg::word_hit(hrbf_pkg::W_CLOSE, 5, s.pos, lc);
                            so.pos = pos_inc(s.pos);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    endfunction

    hrbf_pkg::ln_t   ln_a;
    hrbf_pkg::ln_t   ln_b;
    hrbf_pkg::ln_t   ln_t_end;
    logic [LW-1:0]   val_a;
    logic [LW-1:0]   val_b;
    logic            we_a;
    logic            kv_a;
    logic            we_b;
    logic            kv_b;
    logic            we_e;
    logic            kv_e;

    always_comb
    begin
        ln_next = ln;
        val_next = val;
        pend_cr_next = pend_cr;
        ctl = '0;
        ln_a = ln;
        val_a = val;
        we_a = 1'b0;
        kv_a = 1'b0;
        ln_b = ln;
        val_b = val;
        we_b = 1'b0;
        kv_b = 1'b0;
        ln_t_end = ln;
        we_e = 1'b0;
        kv_e = 1'b0;

        // A CR held back from the previous byte is either a line end or plain text.
        if (pend_cr && data_byte == hrbf_pkg::CH_LF)
        begin
            pend_cr_next = 1'b0;
            ctl.line_done = 1'b1;
            if (!ln.first && ln.stage)
            begin
                unique case (ln.vs)
                    hrbf_pkg::VS_LEN:
                    begin
                        if (ln.bad)
                            ctl.eol_bad = 1'b1;
                        else
                            ctl.len_we = 1'b1;
                    end
                    hrbf_pkg::VS_CONN:
                    begin
                        tok_end(ln, ln_t_end, we_e, kv_e);
                        ctl.ka_we = we_e;
                        ctl.ka_val = kv_e;
                    end
                    hrbf_pkg::VS_TE:
                    begin
                        ctl.chunk_set = ln.nm[0] && ln.pos == 5'd7;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ln_next = hrbf_pkg::LN_START;
            ln_next.first = 1'b0;
            val_next = '0;
        end
        else
        begin
            if (pend_cr)
                char_step(ln, val, hrbf_pkg::CH_CR, ln_a, val_a, we_a, kv_a);
            if (data_byte == hrbf_pkg::CH_CR)
            begin
                pend_cr_next = 1'b1;
                ln_next = ln_a;
                val_next = val_a;
                ctl.ka_we = we_a;
                ctl.ka_val = kv_a;
            end
            else
            begin
                pend_cr_next = 1'b0;
                char_step(ln_a, val_a, data_byte, ln_b, val_b, we_b, kv_b);
                ln_next = ln_b;
                val_next = val_b;
                ctl.ka_we = we_a || we_b;
                ctl.ka_val = we_b ? kv_b : kv_a;
            end
        end
    end

endmodule

### sv/hrbf_core.sv
module hrbf_core #(
    parameter int LENGTH_WIDTH  = hrbf_pkg::LENGTH_WIDTH_DEF,
    parameter int SIZE_LINE_MAX = hrbf_pkg::SIZE_LINE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic [15:0]        max_head_len,
    output hrbf_pkg::res_t     res
);

    localparam int LW = LENGTH_WIDTH;
    localparam int SW = $clog2(SIZE_LINE_MAX + 2);

    logic [2:0]      phase_reg, phase_next;
    logic [LW-1:0]   remaining_reg, remaining_next;
    logic [15:0]     head_count_reg, head_count_next;
    logic            keep_alive_reg, keep_alive_next;
    logic            chunked_reg, chunked_next;
    logic [SW-1:0]   slc_reg, slc_next;
    logic [1:0]      let_reg, let_next;
    logic [2:0]      error_reg, error_next;
    logic            close_reg, close_next;
    logic            pend_cr_reg, pend_cr_next;
    hrbf_pkg::ln_t   ln_reg, ln_next;
    logic [LW-1:0]   val_reg, val_next;

    hrbf_pkg::ln_t     hl_ln;
    logic [LW-1:0]     hl_val;
    logic              hl_pcr;
    hrbf_pkg::hl_ctl_t hl_ctl;

    hrbf_hdr_line #(
        .LENGTH_WIDTH(LW)
    ) u_hdr_line (
        .ln(ln_reg),
        .val(val_reg),
        .pend_cr(pend_cr_reg),
        .data_byte(data_byte),
        .ln_next(hl_ln),
        .val_next(hl_val),
        .pend_cr_next(hl_pcr),
        .ctl(hl_ctl)
    );

    logic          fwd;
    logic          msg_done;
    logic [2:0]    err;
    logic          done;
    logic          sdone;
    logic [LW-1:0] rem_dec;
    logic [LW+3:0] prod;
    logic [3:0]    hex_d;
    logic          hex_ok;
    logic [7:0]    lc;

    always_comb
    begin
        phase_next = phase_reg;
        remaining_next = remaining_reg;
        head_count_next = head_count_reg;
        keep_alive_next = keep_alive_reg;
        chunked_next = chunked_reg;
        slc_next = slc_reg;
        let_next = let_reg;
        error_next = error_reg;
        close_next = close_reg;
        pend_cr_next = pend_cr_reg;
        ln_next = ln_reg;
        val_next = val_reg;
        fwd = 1'b0;
        msg_done = 1'b0;
        err = hrbf_pkg::ERR_NONE;
        done = 1'b0;
        sdone = 1'b0;
        rem_dec = (remaining_reg != '0) ? remaining_reg - LW'(1) : remaining_reg;
        prod = '0;
        lc = hrbf_pkg::to_lower(data_byte);
        hex_ok = 1'b1;
        hex_d = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
            hex_d = 4'(data_byte - 8'h30);
        else if (lc >= 8'h61 && lc <= 8'h66)
            hex_d = 4'(lc - 8'h57);
        else
            hex_ok = 1'b0;

        if (error_reg == hrbf_pkg::ERR_NONE && !close_reg)
        begin
            unique case (phase_reg)
                hrbf_pkg::PH_HEAD:
                begin
                    // Track CR LF CR LF for the blank line that ends the header.
                    if (data_byte == hrbf_pkg::CH_CR)
                        let_next = (let_reg == 2'd2) ? 2'd3 : 2'd1;
                    else if (data_byte == hrbf_pkg::CH_LF)
                    begin
                        done = (let_reg == 2'd3);
                        let_next = (let_reg == 2'd1) ? 2'd2 : 2'd0;
                    end
                    else
                        let_next = 2'd0;
                    ln_next = hl_ln;
                    val_next = hl_val;
                    pend_cr_next = hl_pcr;
                    if (hl_ctl.ka_we) keep_alive_next = hl_ctl.ka_val;
                    if (hl_ctl.len_we)
                    begin
                        remaining_next = val_reg;
                        chunked_next = 1'b0;
                    end
                    if (hl_ctl.chunk_set) chunked_next = 1'b1;
                    if (hl_ctl.eol_bad)
                        err = hrbf_pkg::ERR_LENGTH;
                    else
                    begin
                        if (head_count_reg != 16'hFFFF)
                            head_count_next = head_count_reg + 16'd1;
                        if (done)
                        begin
                            fwd = 1'b1;
                            if (chunked_next)
                            begin
                                phase_next = hrbf_pkg::PH_SIZE;
                                slc_next = '0;
                                val_next = '0;
                                ln_next.bad = 1'b0;
                                pend_cr_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = hrbf_pkg::PH_BODY;
                                msg_done = (remaining_next == '0);
                            end
                        end
                        else if (head_count_next > max_head_len)
                            err = hrbf_pkg::ERR_HEAD_LEN;
                        else
                            fwd = 1'b1;
                    end
                end
                hrbf_pkg::PH_BODY:
                begin
                    fwd = 1'b1;
                    remaining_next = rem_dec;
                    msg_done = (rem_dec == '0);
                end
                hrbf_pkg::PH_SIZE:
                begin
                    if (slc_reg != {SW{1'b1}})
                        slc_next = slc_reg + SW'(1);
                    if (pend_cr_reg)
                    begin
                        pend_cr_next = 1'b0;
                        if (data_byte == hrbf_pkg::CH_LF)
                            sdone = 1'b1;
                        else
                            ln_next.bad = 1'b1;
                    end
                    if (!sdone)
                    begin
                        if (data_byte == hrbf_pkg::CH_CR)
                            pend_cr_next = 1'b1;
                        else if (hex_ok)
                        begin
                            prod = ({4'b0, val_reg} << 4) + (LW+4)'(hex_d);
                            if (prod[LW+3:LW] != 4'd0)
                                ln_next.bad = 1'b1;
                            else
                                val_next = prod[LW-1:0];
                        end
                        else
                            ln_next.bad = 1'b1;
                    end
                    if (sdone)
                    begin
                        if (ln_next.bad)
                            err = hrbf_pkg::ERR_SIZE;
                        else
                        begin
                            fwd = 1'b1;
                            if (val_reg == '0)
                            begin
                                phase_next = hrbf_pkg::PH_FINAL;
                                let_next = 2'd0;
                            end
                            else
                            begin
                                remaining_next = val_reg;
                                phase_next = hrbf_pkg::PH_DATA;
                            end
                        end
                    end
                    else if (slc_next > SW'(SIZE_LINE_MAX))
                        err = hrbf_pkg::ERR_SIZE_LEN;
                    else
                        fwd = 1'b1;
                end
                hrbf_pkg::PH_DATA:
                begin
                    fwd = 1'b1;
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = hrbf_pkg::PH_CRLF;
                        let_next = 2'd0;
                    end
                end
                hrbf_pkg::PH_CRLF, hrbf_pkg::PH_FINAL:
                begin
                    if (let_reg == 2'd0)
                    begin
                        if (data_byte == hrbf_pkg::CH_CR)
                        begin
                            fwd = 1'b1;
                            let_next = 2'd1;
                        end
                        else
                            err = (phase_reg == hrbf_pkg::PH_CRLF) ? hrbf_pkg::ERR_CRLF
                                                                   : hrbf_pkg::ERR_FINAL;
                    end
                    else if (data_byte == hrbf_pkg::CH_LF)
                    begin
                        fwd = 1'b1;
                        let_next = 2'd0;
                        if (phase_reg == hrbf_pkg::PH_CRLF)
                        begin
                            phase_next = hrbf_pkg::PH_SIZE;
                            slc_next = '0;
                            val_next = '0;
                            ln_next.bad = 1'b0;
                            pend_cr_next = 1'b0;
                        end
                        else
                            msg_done = 1'b1;
                    end
                    else
                        err = (phase_reg == hrbf_pkg::PH_CRLF) ? hrbf_pkg::ERR_CRLF
                                                               : hrbf_pkg::ERR_FINAL;
                end
                default:
                begin
                end
            endcase

            if (msg_done)
            begin
                if (keep_alive_next)
                begin
                    phase_next = hrbf_pkg::PH_HEAD;
                    remaining_next = '0;
                    head_count_next = '0;
                    chunked_next = 1'b0;
                    let_next = 2'd0;
                    slc_next = '0;
                    pend_cr_next = 1'b0;
                    ln_next = hrbf_pkg::LN_START;
                    val_next = '0;
                end
                else
                    close_next = 1'b1;
            end
            if (err != hrbf_pkg::ERR_NONE)
            begin
                error_next = err;
                fwd = 1'b0;
                msg_done = 1'b0;
            end
        end

        res.forward = fwd;
        res.phase = phase_reg;
        res.msg_end = msg_done;
        res.close_after = close_next;
        res.error_code = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hrbf_pkg::PH_HEAD;
            remaining_reg <= '0;
            head_count_reg <= '0;
            keep_alive_reg <= 1'b0;
            chunked_reg <= 1'b0;
            slc_reg <= '0;
            let_reg <= 2'd0;
            error_reg <= hrbf_pkg::ERR_NONE;
            close_reg <= 1'b0;
            pend_cr_reg <= 1'b0;
            ln_reg <= hrbf_pkg::LN_START;
            val_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            remaining_reg <= remaining_next;
            head_count_reg <= head_count_next;
            keep_alive_reg <= keep_alive_next;
            chunked_reg <= chunked_next;
            slc_reg <= slc_next;
            let_reg <= let_next;
            error_reg <= error_next;
            close_reg <= close_next;
            pend_cr_reg <= pend_cr_next;
            ln_reg <= ln_next;
            val_reg <= val_next;
        end
    end

endmodule

### sv/http_response_body_framer.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_byte
// out       output     out_valid / out_ready  out_byte, forward, phase, msg_end,
//                                             close_after, error_code
// cfg       input      cfg_wr_en              cfg_wr_data (max_head_len)
//
// Each request produces one result in the cycle after it is accepted; one byte per cycle
// is sustained while out_ready is high, set by the state update in the framing core.
// The output register frees in the same cycle it is taken, so in_ready stays high
// while out_ready is high. A stalled output holds one result and blocks input.
// Reset clears all framing state, and max_head_len returns to 8192.
module http_response_body_framer #(
    parameter int LENGTH_WIDTH  = hrbf_pkg::LENGTH_WIDTH_DEF,
    parameter int SIZE_LINE_MAX = hrbf_pkg::SIZE_LINE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        forward,
    output logic [2:0]  phase,
    output logic        msg_end,
    output logic        close_after,
    output logic [2:0]  error_code,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0]    max_head_len_reg;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg;
    hrbf_pkg::res_t res_reg;
    hrbf_pkg::res_t res;
    logic           accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    hrbf_core #(
        .LENGTH_WIDTH(LENGTH_WIDTH),
        .SIZE_LINE_MAX(SIZE_LINE_MAX)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(accept),
        .data_byte(data_byte),
        .max_head_len(max_head_len_reg),
        .res(res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_head_len_reg <= hrbf_pkg::MAX_HEAD_LEN_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_head_len_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg <= data_byte;
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign forward = res_reg.forward;
    assign phase = res_reg.phase;
    assign msg_end = res_reg.msg_end;
    assign close_after = res_reg.close_after;
    assign error_code = res_reg.error_code;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != hrbf_pkg::ERR_NONE) |-> (!forward && !msg_end))
        else $error("byte forwarded after an error");

    a_end_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && msg_end) |-> forward)
        else $error("message end on a dropped byte");

    a_close_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && close_after && !msg_end) |-> !forward)
        else $error("byte forwarded after close");

endmodule

### tb/sv/http_response_body_framer_tb.sv
`timescale 1ns / 1ps

module http_response_body_framer_tb;

    localparam logic [63:0] LEN_MASK = 64'h0000_0000_FFFF_FFFF;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 650;

    typedef struct {
        logic [7:0]     data;
        hrbf_pkg::res_t res;
    } framed_byte_t;

    typedef struct {
        bit             typed;
        hrbf_pkg::res_t res;
    } typed_tag_t;

    typedef struct {
        string          text;
        bit             typed;
        hrbf_pkg::res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        forward;
    logic [2:0]  phase;
    logic        msg_end;
    logic        close_after;
    logic [2:0]  error_code;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    http_response_body_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .forward     (forward),
        .phase       (phase),
        .msg_end     (msg_end),
        .close_after (close_after),
        .error_code  (error_code),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the framer state.
    logic [15:0] head_limit;
    logic [2:0]  cur_phase;
    logic [63:0] bytes_left;
    logic [15:0] head_cnt;
    bit          ka;
    bit          chunked;
    bit          closing;
    logic [2:0]  err_latched;
    logic [7:0]  cand;
    logic [1:0]  vkind;
    logic [7:0]  size_cnt;
    logic [1:0]  eol_track;
    bit          first_line;
    bit          in_value;
    bit          saw_ws;
    bit          started;
    bit          bad;
    bit          cr_pending;
    bit          msg_done;
    logic [7:0]  pos;
    logic [63:0] acc;

    framed_byte_t expected_bytes[$];
    typed_tag_t   tag_q[$];
    int           fails;
    int           items_sent;
    int           idle_cnt;
    bit           calm;
    logic [7:0]   msg_q[$];

    function logic [7:0] lower_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function bit blank_char(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function logic [7:0] drop_cand(input logic [7:0] m, input logic [7:0] sel,
                                   input string w, input logic [7:0] c);
        if ((m & sel) != 0 && (pos >= w.len() || w[pos] != c))
            m = m & ~sel;
        return m;
    endfunction

    function void line_reset();
        cand = 8'd7;
        vkind = hrbf_pkg::VS_NONE;
        in_value = 0;
        pos = 0;
        saw_ws = 0;
        started = 0;
        bad = 0;
        acc = 0;
    endfunction

    function void new_message();
        cur_phase = hrbf_pkg::PH_HEAD;
        bytes_left = 0;
        head_cnt = 0;
        chunked = 0;
        eol_track = 0;
        size_cnt = 0;
        cr_pending = 0;
        line_reset();
        first_line = 1;
    endfunction

    function void reset_framer_model();
        head_limit = hrbf_pkg::MAX_HEAD_LEN_RST;
        ka = 0;
        err_latched = hrbf_pkg::ERR_NONE;
        closing = 0;
        new_message();
    endfunction

    function void token_end();
        if (cand[0] && pos == 10)
            ka = 1;
        else if (cand[1] && pos == 5)
            ka = 0;
        cand = 8'd3;
        pos = 0;
        saw_ws = 0;
        started = 0;
    endfunction

    function void header_char(input logic [7:0] c);
        logic [7:0]  lc;
        logic [1:0]  kind;
        logic [63:0] d;
        lc = lower_char(c);
        if (first_line)
            return;
        if (!in_value)
        begin
            if (c == hrbf_pkg::CH_COLON)
            begin
                kind = hrbf_pkg::VS_NONE;
                if (cand[0] && pos == 14)
                    kind = hrbf_pkg::VS_LEN;
                if (cand[1] && pos == 10)
                    kind = hrbf_pkg::VS_CONN;
                if (cand[2] && pos == 17)
                    kind = hrbf_pkg::VS_TE;
                vkind = kind;
                in_value = 1;
                pos = 0;
                saw_ws = 0;
                started = 0;
                bad = 0;
                acc = 0;
                cand = (kind == hrbf_pkg::VS_CONN) ? 8'd3 : 8'd1;
                return;
            end
            if (blank_char(c))
            begin
                saw_ws = 1;
                return;
            end
            if (saw_ws)
                cand = 0;
            cand = drop_cand(cand, 8'd1, "content-length", lc);
            cand = drop_cand(cand, 8'd2, "connection", lc);
            cand = drop_cand(cand, 8'd4, "transfer-encoding", lc);
            if (pos != 8'd255)
                pos++;
            return;
        end
        case (vkind)
            hrbf_pkg::VS_LEN:
            begin
                if (!started && blank_char(c))
                    return;
                started = 1;
                if (c >= "0" && c <= "9")
                begin
                    d = 64'(c - "0");
                    if (acc > (LEN_MASK - d) / 10)
                        bad = 1;
                    else
                        acc = acc * 10 + d;
                end
                else
                    bad = 1;
            end
            hrbf_pkg::VS_TE:
            begin
                if (!started && blank_char(c))
                    return;
                started = 1;
                cand = drop_cand(cand, 8'd1, "chunked", lc);
                if (pos != 8'd255)
                    pos++;
            end
            hrbf_pkg::VS_CONN:
            begin
                if (c == hrbf_pkg::CH_SEMI)
                begin
                    token_end();
                    return;
                end
                if (blank_char(c))
                begin
                    if (started)
                        saw_ws = 1;
                    return;
                end
                if (saw_ws)
                    cand = 0;
                started = 1;
                cand = drop_cand(cand, 8'd1, "keep-alive", lc);
                cand = drop_cand(cand, 8'd2, "close", lc);
                if (pos != 8'd255)
                    pos++;
            end
            default:
            begin
            end
        endcase
    endfunction

    function bit header_line_end();
        bit is_bad;
        is_bad = 0;
        if (!first_line && in_value)
        begin
            if (vkind == hrbf_pkg::VS_LEN)
            begin
                if (bad)
                    is_bad = 1;
                else
                begin
                    bytes_left = acc;
                    chunked = 0;
                end
            end
            else if (vkind == hrbf_pkg::VS_CONN)
                token_end();
            else if (vkind == hrbf_pkg::VS_TE && cand[0] && pos == 7)
                chunked = 1;
        end
        line_reset();
        first_line = 0;
        return is_bad;
    endfunction

    // Tracks CR LF CR LF; returns 1 on the LF that ends the header.
    function bit blank_line_seen(input logic [7:0] b);
        logic [1:0] s;
        s = eol_track;
        if (b == hrbf_pkg::CH_CR)
            eol_track = (s == 2) ? 2'd3 : 2'd1;
        else if (b == hrbf_pkg::CH_LF)
        begin
            if (s == 3)
            begin
                eol_track = 0;
                return 1;
            end
            eol_track = (s == 1) ? 2'd2 : 2'd0;
        end
        else
            eol_track = 0;
        return 0;
    endfunction

    function void size_line_start();
        cur_phase = hrbf_pkg::PH_SIZE;
        size_cnt = 0;
        acc = 0;
        bad = 0;
        cr_pending = 0;
    endfunction

    function void size_char(input logic [7:0] c);
        logic [7:0]  lc;
        logic [63:0] d;
        lc = lower_char(c);
        if (c >= "0" && c <= "9")
            d = 64'(c - "0");
        else if (lc >= "a" && lc <= "f")
            d = 64'(lc - "a" + 10);
        else
        begin
            bad = 1;
            return;
        end
        if (acc > (LEN_MASK - d) / 16)
            bad = 1;
        else
            acc = acc * 16 + d;
    endfunction

    function void message_done();
        msg_done = 1;
        if (ka)
            new_message();
        else
            closing = 1;
    endfunction

    function hrbf_pkg::res_t frame_byte(input logic [7:0] b);
        logic [2:0]     ph;
        logic [2:0]     err;
        logic [2:0]     code;
        bit             fwd;
        bit             done;
        bit             line_done;
        hrbf_pkg::res_t r;
        ph = cur_phase;
        fwd = 0;
        msg_done = 0;
        err = hrbf_pkg::ERR_NONE;
        if (err_latched == hrbf_pkg::ERR_NONE && !closing)
        begin
            case (cur_phase)
                hrbf_pkg::PH_HEAD:
                begin
                    done = blank_line_seen(b);
                    line_done = 0;
                    if (cr_pending)
                    begin
                        cr_pending = 0;
                        if (b == hrbf_pkg::CH_LF)
                        begin
                            line_done = 1;
                            if (header_line_end())
                                err = hrbf_pkg::ERR_LENGTH;
                        end
                        else
                            header_char(hrbf_pkg::CH_CR);
                    end
                    if (!line_done)
                    begin
                        if (b == hrbf_pkg::CH_CR)
                            cr_pending = 1;
                        else
                            header_char(b);
                    end
                    if (err == hrbf_pkg::ERR_NONE)
                    begin
                        if (head_cnt != 16'hFFFF)
                            head_cnt++;
                        if (done)
                        begin
                            fwd = 1;
                            if (chunked)
                                size_line_start();
                            else
                            begin
                                cur_phase = hrbf_pkg::PH_BODY;
                                if (bytes_left == 0)
                                    message_done();
                            end
                        end
                        else if (head_cnt > head_limit)
                            err = hrbf_pkg::ERR_HEAD_LEN;
                        else
                            fwd = 1;
                    end
                end
                hrbf_pkg::PH_BODY, hrbf_pkg::PH_DATA:
                begin
                    fwd = 1;
                    if (bytes_left != 0)
                        bytes_left = (bytes_left - 1) & LEN_MASK;
                    if (bytes_left == 0)
                    begin
                        if (cur_phase == hrbf_pkg::PH_BODY)
                            message_done();
                        else
                        begin
                            cur_phase = hrbf_pkg::PH_CRLF;
                            eol_track = 0;
                        end
                    end
                end
                hrbf_pkg::PH_SIZE:
                begin
                    done = 0;
                    if (size_cnt != 8'd255)
                        size_cnt++;
                    if (cr_pending)
                    begin
                        cr_pending = 0;
                        if (b == hrbf_pkg::CH_LF)
                            done = 1;
                        else
                            bad = 1;
                    end
                    if (!done)
                    begin
                        if (b == hrbf_pkg::CH_CR)
                            cr_pending = 1;
                        else
                            size_char(b);
                    end
                    if (done)
                    begin
                        if (bad)
                            err = hrbf_pkg::ERR_SIZE;
                        else
                        begin
                            fwd = 1;
                            if (acc == 0)
                            begin
                                cur_phase = hrbf_pkg::PH_FINAL;
                                eol_track = 0;
                            end
                            else
                            begin
                                bytes_left = acc & LEN_MASK;
                                cur_phase = hrbf_pkg::PH_DATA;
                            end
                        end
                    end
                    else if (size_cnt > hrbf_pkg::SIZE_LINE_MAX_DEF)
                        err = hrbf_pkg::ERR_SIZE_LEN;
                    else
                        fwd = 1;
                end
                hrbf_pkg::PH_CRLF, hrbf_pkg::PH_FINAL:
                begin
                    code = (cur_phase == hrbf_pkg::PH_CRLF) ? hrbf_pkg::ERR_CRLF
                                                            : hrbf_pkg::ERR_FINAL;
                    if (eol_track == 0)
                    begin
                        if (b == hrbf_pkg::CH_CR)
                        begin
                            fwd = 1;
                            eol_track = 1;
                        end
                        else
                            err = code;
                    end
                    else if (b == hrbf_pkg::CH_LF)
                    begin
                        fwd = 1;
                        eol_track = 0;
                        if (cur_phase == hrbf_pkg::PH_CRLF)
                            size_line_start();
                        else
                            message_done();
                    end
                    else
                        err = code;
                end
                default:
                begin
                end
            endcase
            if (err != hrbf_pkg::ERR_NONE)
            begin
                err_latched = err;
                fwd = 0;
                msg_done = 0;
            end
        end
        r.forward = fwd;
        r.phase = ph;
        r.msg_end = msg_done;
        r.close_after = closing;
        r.error_code = err_latched;
        return r;
    endfunction

    // Scoreboard: results are checked before the new request is predicted.
    always @(posedge clk)
    begin
        framed_byte_t   e;
        typed_tag_t     t;
        hrbf_pkg::res_t p;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("result with no request pending: out_byte %0h", out_byte);
                    fails++;
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (out_byte !== e.data)
                    begin
                        $error("out_byte expected %0h actual %0h", e.data, out_byte);
                        fails++;
                    end
                    if (forward !== e.res.forward)
                    begin
                        $error("forward expected %0d actual %0d", e.res.forward, forward);
                        fails++;
                    end
                    if (phase !== e.res.phase)
                    begin
                        $error("phase expected %0d actual %0d", e.res.phase, phase);
                        fails++;
                    end
                    if (msg_end !== e.res.msg_end)
                    begin
                        $error("msg_end expected %0d actual %0d", e.res.msg_end, msg_end);
                        fails++;
                    end
                    if (close_after !== e.res.close_after)
                    begin
                        $error("close_after expected %0d actual %0d",
                               e.res.close_after, close_after);
                        fails++;
                    end
                    if (error_code !== e.res.error_code)
                    begin
                        $error("error_code expected %0d actual %0d",
                               e.res.error_code, error_code);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                t = tag_q.pop_front();
                p = frame_byte(data_byte);
                e.data = data_byte;
                e.res = t.typed ? t.res : p;
                expected_bytes.push_back(e);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 35);
    end

    task automatic send_byte(input logic [7:0] b, input bit typed, input hrbf_pkg::res_t r);
        typed_tag_t t;
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        t.typed = typed;
        t.res = r;
        tag_q.push_back(t);
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        calm = (items_sent > 250 && items_sent < 400);
    endtask

    task automatic send_msg();
        hrbf_pkg::res_t none;
        none = '0;
        foreach (msg_q[i])
            send_byte(msg_q[i], 1'b0, none);
        msg_q.delete();
    endtask

    task automatic write_head_limit(input logic [15:0] v);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        head_limit = v;
        cfg_wr_en <= 1'b0;
    endtask

    function void push_text(input string s);
        foreach (s[i])
            msg_q.push_back(s[i]);
    endfunction

    // Letters get a random case; the framer matches names and tokens case-blind.
    function void push_mixed(input string s);
        logic [7:0] c;
        foreach (s[i])
        begin
            c = s[i];
            if (lower_char(c) >= "a" && lower_char(c) <= "z" && $urandom_range(1))
                c = c ^ 8'h20;
            msg_q.push_back(c);
        end
    endfunction

    function void push_noise_line();
        int n;
        logic [7:0] c;
        if ($urandom_range(3) == 0)
        begin
            push_text("no colon line\r\n");
            return;
        end
        push_mixed("X-Extra:");
        n = $urandom_range(12);
        repeat (n)
        begin
            c = 8'($urandom_range(255));
            if (c == hrbf_pkg::CH_CR || c == hrbf_pkg::CH_LF)
            begin
                // A CR that is not followed by LF is plain line content.
                msg_q.push_back(hrbf_pkg::CH_CR);
                c = "q";
            end
            msg_q.push_back(c);
        end
        push_text("\r\n");
    endfunction

    function void push_head(input bit chunk, input int len);
        string conn[4];
        conn = '{"Keep-Alive", "close; keep-alive", " keep-alive ", "foo;Keep-Alive"};
        push_text($sformatf("HTTP/1.1 %0d OK\r\n", $urandom_range(100, 599)));
        repeat ($urandom_range(2))
            push_noise_line();
        push_mixed("Connection:");
        push_mixed(conn[$urandom_range(3)]);
        push_text("\r\n");
        if ($urandom_range(3) == 0)
            push_mixed("Transfer-Encoding: gzip\r\n");
        if (chunk)
        begin
            if ($urandom_range(3) == 0)
                push_mixed("Content-Length: 5\r\n");
            push_mixed("Transfer-Encoding:  chunked\r\n");
        end
        else
        begin
            if ($urandom_range(3) == 0)
                push_mixed("Transfer-Encoding: chunked\r\n");
            push_mixed("Content-Length:");
            if ($urandom_range(1))
                push_text(" ");
            if (len != 0 || $urandom_range(1))
                push_text($sformatf("%0d", len));
            push_text("\r\n");
        end
        repeat ($urandom_range(1))
            push_noise_line();
        push_text("\r\n");
    endfunction

    function void push_random_message();
        bit chunk;
        int len;
        chunk = $urandom_range(1);
        len = $urandom_range(24);
        push_head(chunk, len);
        if (!chunk)
        begin
            repeat (len)
                msg_q.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(1, 3))
        begin
            len = $urandom_range(1, 20);
            if ($urandom_range(1))
                push_text("0");
            push_mixed($sformatf("%0h\r\n", len));
            repeat (len)
                msg_q.push_back(8'($urandom_range(255)));
            push_text("\r\n");
        end
        if ($urandom_range(1))
            push_text("00\r\n");
        else
            push_text("\r\n");
        push_text("\r\n");
    endfunction

    dir_row_t dir_rows[8];

    initial
    begin
        int             kind;
        hrbf_pkg::res_t none;
        none = '0;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'h00;
        out_ready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 16'h0000;
        fails = 0;
        items_sent = 0;
        idle_cnt = 0;
        calm = 0;
        reset_framer_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        dir_rows = '{
            '{"H", 1'b1, '{forward: 1'b1, phase: hrbf_pkg::PH_HEAD, msg_end: 1'b0,
                           close_after: 1'b0, error_code: hrbf_pkg::ERR_NONE}},
            '{"\r\nconnection: close ;Keep-Alive \r\nContent-Length:2\r\n\r\na", 1'b0, '0},
            '{"b", 1'b1, '{forward: 1'b1, phase: hrbf_pkg::PH_BODY, msg_end: 1'b1,
                           close_after: 1'b0, error_code: hrbf_pkg::ERR_NONE}},
            '{"S\r\nContent-Length:\r\n\r", 1'b0, '0},
            '{"\n", 1'b1, '{forward: 1'b1, phase: hrbf_pkg::PH_HEAD, msg_end: 1'b1,
                            close_after: 1'b0, error_code: hrbf_pkg::ERR_NONE}},
            '{"S\r\nTRANSFER-ENCODING: chunked\r\n\r\n1\r\nZ\r\n\r\n\r", 1'b0, '0},
            '{"\n", 1'b1, '{forward: 1'b1, phase: hrbf_pkg::PH_FINAL, msg_end: 1'b1,
                            close_after: 1'b0, error_code: hrbf_pkg::ERR_NONE}},
            '{"S\r\n\r\n", 1'b0, '0}
        };
        foreach (dir_rows[r])
            foreach (dir_rows[r].text[i])
                send_byte(dir_rows[r].text[i],
                          dir_rows[r].typed && i == dir_rows[r].text.len() - 1,
                          dir_rows[r].res);

        // The last directed message had no length, so it ended on its header.
        write_head_limit(16'hFFFF);
        while (items_sent < RANDOM_ITEMS / 3)
        begin
            push_random_message();
            send_msg();
        end
        write_head_limit(16'($urandom_range(256, 65534)));
        while (items_sent < 2 * RANDOM_ITEMS / 3)
        begin
            push_random_message();
            send_msg();
        end
        write_head_limit(16'd1000);
        while (items_sent < RANDOM_ITEMS)
        begin
            push_random_message();
            send_msg();
        end

        // One terminal case per run, since both errors and close latch until reset.
        kind = $urandom_range(7);
        case (kind)
            0: push_mixed("H\r\nConnection: close\r\nContent-Length: 2\r\n\r\nxy");
            1:
            begin
                write_head_limit(16'd0);
                push_text("HTTP/1.1 200 OK\r\n");
            end
            2: push_mixed("H\r\nContent-Length: 1x\r\n");
            3:
            begin
                push_head(1'b1, 0);
                push_text("g\r\n");
            end
            4:
            begin
                push_head(1'b1, 0);
                repeat (31)
                    push_text("0");
            end
            5:
            begin
                push_head(1'b1, 0);
                push_text("1\r\nAB");
            end
            6:
            begin
                push_head(1'b1, 0);
                push_text("0\r\n\rX");
            end
            default: push_mixed("H\r\nContent-Length: 99999999999\r\n");
        endcase
        push_text("\r\nzz\r\n\r\n");
        send_msg();
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
